// ===== rtl/core/srtp_pkg.sv =====
// Shared types and constants for the two-pass spike remover.
// No dependencies; every other file of the block uses it.
package srtp_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int TOL_W          = 15;
  localparam int CFG_IDX_W      = 1;
  localparam int PASSES_DEFAULT = 2;

  localparam logic [TOL_W-1:0] INTERIOR_TOL_RESET = 15'd80;
  localparam logic [TOL_W-1:0] EDGE_TOL_RESET     = 15'd160;

  localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOL     = 1'b1;

  typedef enum logic [1:0] {
    FILL_EMPTY,
    FILL_ONE,
    FILL_TWO,
    FILL_FULL
  } fill_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] shift_x;
    logic signed [SAMPLE_W-1:0] shift_y;
    logic                       is_final;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] clean_x;
    logic signed [SAMPLE_W-1:0] clean_y;
    logic                       run_end;
  } out_word_t;

  // word carried between passes
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic                       fin;
  } pair_t;

endpackage

// ===== rtl/core/srtp_lane.sv =====
// One channel of a pass: interior mean and end-sample extrapolation on a
// three-sample window. Depends on srtp_pkg.
module srtp_lane (
  input  logic signed [srtp_pkg::SAMPLE_W-1:0] p_i,
  input  logic signed [srtp_pkg::SAMPLE_W-1:0] m_i,
  input  logic signed [srtp_pkg::SAMPLE_W-1:0] n_i,
  input  logic        [srtp_pkg::TOL_W-1:0]    interior_tol_i,
  input  logic        [srtp_pkg::TOL_W-1:0]    edge_tol_i,
  output logic signed [srtp_pkg::SAMPLE_W-1:0] inner_o,
  output logic signed [srtp_pkg::SAMPLE_W-1:0] edge_lo_o,
  output logic signed [srtp_pkg::SAMPLE_W-1:0] edge_hi_o
);

  localparam int W = srtp_pkg::SAMPLE_W;

  function automatic logic [W:0] mag_diff(input logic signed [W-1:0] a,
                                          input logic signed [W-1:0] b);
    logic signed [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    mag_diff = d[W] ? -d : d;
  endfunction

  function automatic logic [W:0] mag(input logic signed [W-1:0] a);
    logic [W:0] e;
    e = {a[W-1], a};
    mag = a[W-1] ? -e : e;
  endfunction

  // replace e by 2*nb - far when it jumps away from nb and is larger
  function automatic logic signed [W-1:0] fix_edge(input logic signed [W-1:0] e,
                                                   input logic signed [W-1:0] nb,
                                                   input logic signed [W-1:0] far,
                                                   input logic [srtp_pkg::TOL_W-1:0] tol);
    logic signed [W+1:0] ex;
    logic                jump;
    ex   = {nb[W-1], nb, 1'b0} - {{2{far[W-1]}}, far};
    jump = (mag_diff(e, nb) > (W+1)'(tol)) && (mag(e) > mag(nb));
    if (!jump) begin
      fix_edge = e;
    end else if (ex[W+1:W-1] == 3'b000 || ex[W+1:W-1] == 3'b111) begin
      fix_edge = ex[W-1:0];
    end else if (ex[W+1]) begin
      fix_edge = {1'b1, {(W-1){1'b0}}};
    end else begin
      fix_edge = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  logic signed [W:0] sum;
  logic signed [W:0] sum_adj;
  logic              spike;

  // mean truncated toward zero: bias negative sums by one before halving
  assign sum     = {p_i[W-1], p_i} + {n_i[W-1], n_i};
  assign sum_adj = sum + {{W{1'b0}}, sum[W]};
  assign spike   = (mag_diff(m_i, p_i) >= (W+1)'(interior_tol_i)) &&
                   (mag_diff(m_i, n_i) >= (W+1)'(interior_tol_i));

  assign inner_o   = spike ? sum_adj[W:1] : m_i;
  assign edge_lo_o = fix_edge(p_i, m_i, n_i, edge_tol_i);
  assign edge_hi_o = fix_edge(n_i, m_i, p_i, edge_tol_i);

endmodule

// ===== rtl/core/srtp_pass.sv =====
// One spike-removal pass: sample window, fill-state sequencer, x and y lanes,
// and a four-word output queue that merges the lane results. Depends on
// srtp_pkg and srtp_lane.
module srtp_pass (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [srtp_pkg::TOL_W-1:0]    interior_tol,
  input  logic [srtp_pkg::TOL_W-1:0]    edge_tol,
  input  logic                          in_valid,
  input  srtp_pkg::pair_t               in_word,
  output logic                          in_ready,
  output logic                          out_valid,
  output srtp_pkg::pair_t               out_word,
  input  logic                          out_ready
);

  localparam int W = srtp_pkg::SAMPLE_W;

  srtp_pkg::fill_state_t state_r, state_nxt;
  logic signed [W-1:0]   w_x_r [3];
  logic signed [W-1:0]   w_y_r [3];
  srtp_pkg::pair_t       q_r [4];
  srtp_pkg::pair_t       q_nxt [4];
  logic [2:0]            cnt_r, cnt_nxt;
  logic [2:0]            base;
  logic [2:0]            slot;
  logic                  take;
  logic                  pop;
  logic [1:0]            push_n;
  srtp_pkg::pair_t       push_w [3];

  logic signed [W-1:0] p_x, m_x, p_y, m_y;
  logic signed [W-1:0] inner_x, edge_lo_x, edge_hi_x;
  logic signed [W-1:0] inner_y, edge_lo_y, edge_hi_y;

  assign take      = in_valid && in_ready;
  assign in_ready  = (cnt_r <= 3'd1);
  assign out_valid = (cnt_r != 3'd0);
  assign out_word  = q_r[0];
  assign pop       = out_valid && out_ready;

  // once full, the window slides: (older, middle, incoming)
  assign p_x = (state_r == srtp_pkg::FILL_FULL) ? w_x_r[1] : w_x_r[0];
  assign m_x = (state_r == srtp_pkg::FILL_FULL) ? w_x_r[2] : w_x_r[1];
  assign p_y = (state_r == srtp_pkg::FILL_FULL) ? w_y_r[1] : w_y_r[0];
  assign m_y = (state_r == srtp_pkg::FILL_FULL) ? w_y_r[2] : w_y_r[1];

  srtp_lane u_lane_x (
    .p_i            (p_x),
    .m_i            (m_x),
    .n_i            (in_word.x),
    .interior_tol_i (interior_tol),
    .edge_tol_i     (edge_tol),
    .inner_o        (inner_x),
    .edge_lo_o      (edge_lo_x),
    .edge_hi_o      (edge_hi_x)
  );

  srtp_lane u_lane_y (
    .p_i            (p_y),
    .m_i            (m_y),
    .n_i            (in_word.y),
    .interior_tol_i (interior_tol),
    .edge_tol_i     (edge_tol),
    .inner_o        (inner_y),
    .edge_lo_o      (edge_lo_y),
    .edge_hi_o      (edge_hi_y)
  );

  always_comb begin
    state_nxt = state_r;
    if (take) begin
      if (in_word.fin) begin
        state_nxt = srtp_pkg::FILL_EMPTY;
      end else begin
        case (state_r)
          srtp_pkg::FILL_EMPTY: state_nxt = srtp_pkg::FILL_ONE;
          srtp_pkg::FILL_ONE:   state_nxt = srtp_pkg::FILL_TWO;
          default:              state_nxt = srtp_pkg::FILL_FULL;
        endcase
      end
    end
  end

  // words produced by this item, in order
  always_comb begin
    push_n    = 2'd0;
    push_w[0] = in_word;
    push_w[1] = in_word;
    push_w[2] = in_word;
    case (state_r)
      srtp_pkg::FILL_EMPTY: begin
        push_n = {1'b0, take && in_word.fin};
      end
      srtp_pkg::FILL_ONE: begin
        push_w[0] = '{x: w_x_r[0], y: w_y_r[0], fin: 1'b0};
        push_n    = (take && in_word.fin) ? 2'd2 : 2'd0;
      end
      srtp_pkg::FILL_TWO: begin
        push_w[0] = '{x: edge_lo_x, y: edge_lo_y, fin: 1'b0};
        push_w[1] = '{x: inner_x, y: inner_y, fin: 1'b0};
        push_w[2] = '{x: edge_hi_x, y: edge_hi_y, fin: 1'b1};
        push_n    = take ? (in_word.fin ? 2'd3 : 2'd2) : 2'd0;
      end
      srtp_pkg::FILL_FULL: begin
        push_w[0] = '{x: inner_x, y: inner_y, fin: 1'b0};
        push_w[1] = '{x: edge_hi_x, y: edge_hi_y, fin: 1'b1};
        push_n    = take ? (in_word.fin ? 2'd2 : 2'd1) : 2'd0;
      end
      default: begin
        push_n = 2'd0;
      end
    endcase
  end

  // queue: shift out at the head, append behind what remains
  always_comb begin
    q_nxt = q_r;
    slot  = 3'd0;
    if (pop) begin
      for (int i = 0; i < 3; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    base = cnt_r - {2'b00, pop};
    for (int j = 0; j < 3; j++) begin
      slot = base + 3'(j);
      if (2'(j) < push_n) begin
        q_nxt[slot[1:0]] = push_w[j];
      end
    end
    cnt_nxt = base + {1'b0, push_n};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srtp_pkg::FILL_EMPTY;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (take) begin
      case (state_r)
        srtp_pkg::FILL_EMPTY: begin
          w_x_r[0] <= in_word.x;
          w_y_r[0] <= in_word.y;
        end
        srtp_pkg::FILL_ONE: begin
          w_x_r[1] <= in_word.x;
          w_y_r[1] <= in_word.y;
        end
        srtp_pkg::FILL_TWO: begin
          w_x_r[2] <= in_word.x;
          w_y_r[2] <= in_word.y;
        end
        default: begin
          w_x_r[0] <= w_x_r[1];
          w_y_r[0] <= w_y_r[1];
          w_x_r[1] <= w_x_r[2];
          w_y_r[1] <= w_y_r[2];
          w_x_r[2] <= in_word.x;
          w_y_r[2] <= in_word.y;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/spike_remover_two_pass_unit.sv =====
// Spike remover for (x, y) shift streams: PASS_COUNT cascaded passes.
// Each pass queues a sample's word when the next sample is taken (the first waits for the
// third), so words trail the input by PASS_COUNT samples, registered in each pass's queue.
// Throughput: one word per cycle while out_stall is low; each pass stalls its input when its
// window first fills, and while a final word flushes up to three words.
// Reset: tolerances to 5.0 and 10.0 (Q11.4), all windows and queues empty.
module spike_remover_two_pass_unit #(
  parameter int PASS_COUNT = srtp_pkg::PASSES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [srtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srtp_pkg::TOL_W-1:0]      cfg_data,
  input  logic                            in_valid,
  input  srtp_pkg::in_word_t              in_word,
  output logic                            in_stall,
  output logic                            out_valid,
  output srtp_pkg::out_word_t             out_word,
  input  logic                            out_stall
);

  logic [srtp_pkg::TOL_W-1:0] interior_tol_r;
  logic [srtp_pkg::TOL_W-1:0] edge_tol_r;

  logic            link_valid [PASS_COUNT+1];
  logic            link_ready [PASS_COUNT+1];
  srtp_pkg::pair_t link_word  [PASS_COUNT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interior_tol_r <= srtp_pkg::INTERIOR_TOL_RESET;
      edge_tol_r     <= srtp_pkg::EDGE_TOL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        srtp_pkg::REG_INTERIOR_TOL: interior_tol_r <= cfg_data;
        srtp_pkg::REG_EDGE_TOL:     edge_tol_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign link_valid[0] = in_valid;
  assign link_word[0]  = '{x: in_word.shift_x, y: in_word.shift_y, fin: in_word.is_final};
  assign in_stall      = !link_ready[0];

  for (genvar k = 0; k < PASS_COUNT; k++) begin : g_pass
    srtp_pass u_pass (
      .clk          (clk),
      .rst_n        (rst_n),
      .interior_tol (interior_tol_r),
      .edge_tol     (edge_tol_r),
      .in_valid     (link_valid[k]),
      .in_word      (link_word[k]),
      .in_ready     (link_ready[k]),
      .out_valid    (link_valid[k+1]),
      .out_word     (link_word[k+1]),
      .out_ready    (link_ready[k+1])
    );
  end

  assign link_ready[PASS_COUNT] = !out_stall;
  assign out_valid              = link_valid[PASS_COUNT];
  assign out_word               = '{clean_x: link_word[PASS_COUNT].x,
                                    clean_y: link_word[PASS_COUNT].y,
                                    run_end: link_word[PASS_COUNT].fin};

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for spike_remover_two_pass_unit.
// Predicts every cleaned word from its own model of the cascaded passes.
// Drives random gaps and stalls; uses srtp_pkg for word types and register codes.
`timescale 1ns / 100ps

module testbench;

  localparam int PASSES       = srtp_pkg::PASSES_DEFAULT;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam longint SAMPLE_MAX = (longint'(1) << (srtp_pkg::SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [srtp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [srtp_pkg::TOL_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  srtp_pkg::in_word_t             in_word = '0;
  logic                           in_stall;
  logic                           out_valid;
  srtp_pkg::out_word_t            out_word;
  logic                           out_stall = 1'b0;

  spike_remover_two_pass_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: tolerances, per-pass three-pair windows and fill levels
  longint                interior_tol = longint'(srtp_pkg::INTERIOR_TOL_RESET);
  longint                edge_tol     = longint'(srtp_pkg::EDGE_TOL_RESET);
  longint                win_x [PASSES][3];
  longint                win_y [PASSES][3];
  srtp_pkg::fill_state_t pass_fill [PASSES];
  srtp_pkg::pair_t       pass_out [$];

  srtp_pkg::in_word_t    pending_words [$];
  srtp_pkg::out_word_t   clean_words_due [$];
  int          fail_count = 0;
  int          tx_max_gap = 7;
  int          rx_max_gap = 7;
  int          tx_gap = 0;
  int          rx_wait = 0;
  int          quiet_cycles = 0;
  longint      walk [2] = '{0, 0};

  initial begin
    for (int k = 0; k < PASSES; k++) begin
      pass_fill[k] = srtp_pkg::FILL_EMPTY;
      for (int j = 0; j < 3; j++) begin
        win_x[k][j] = 0;
        win_y[k][j] = 0;
      end
    end
  end

  function automatic longint sat_sample(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // End sample: extrapolate from the two inner neighbours on a large outward jump
  function automatic longint fix_end(longint e, longint nb, longint far);
    if (magnitude(e - nb) > edge_tol && magnitude(e) > magnitude(nb))
      return sat_sample(2 * nb - far);
    return e;
  endfunction

  // Interior sample: truncated mean of neighbours when it jumps from both
  function automatic longint fix_mid(longint prev, longint mid, longint next);
    if (magnitude(mid - prev) >= interior_tol && magnitude(mid - next) >= interior_tol)
      return (prev + next) / 2;
    return mid;
  endfunction

  function automatic srtp_pkg::pair_t make_pair(longint x, longint y, logic fin);
    srtp_pkg::pair_t p;
    p.x   = x[srtp_pkg::SAMPLE_W-1:0];
    p.y   = y[srtp_pkg::SAMPLE_W-1:0];
    p.fin = fin;
    return p;
  endfunction

  function automatic void pass_step(int k, srtp_pkg::pair_t s);
    case (pass_fill[k])
      srtp_pkg::FILL_EMPTY: begin
        win_x[k][0] = s.x;
        win_y[k][0] = s.y;
        if (s.fin) begin
          pass_out.push_back(s);
          pass_fill[k] = srtp_pkg::FILL_EMPTY;
        end else begin
          pass_fill[k] = srtp_pkg::FILL_ONE;
        end
      end
      srtp_pkg::FILL_ONE: begin
        win_x[k][1] = s.x;
        win_y[k][1] = s.y;
        if (s.fin) begin
          pass_out.push_back(make_pair(win_x[k][0], win_y[k][0], 1'b0));
          pass_out.push_back(s);
          pass_fill[k] = srtp_pkg::FILL_EMPTY;
        end else begin
          pass_fill[k] = srtp_pkg::FILL_TWO;
        end
      end
      srtp_pkg::FILL_TWO: begin
        win_x[k][2] = s.x;
        win_y[k][2] = s.y;
        pass_out.push_back(make_pair(fix_end(win_x[k][0], win_x[k][1], win_x[k][2]),
                                     fix_end(win_y[k][0], win_y[k][1], win_y[k][2]), 1'b0));
        pass_out.push_back(make_pair(fix_mid(win_x[k][0], win_x[k][1], win_x[k][2]),
                                     fix_mid(win_y[k][0], win_y[k][1], win_y[k][2]), 1'b0));
        if (s.fin) begin
          pass_out.push_back(make_pair(fix_end(win_x[k][2], win_x[k][1], win_x[k][0]),
                                       fix_end(win_y[k][2], win_y[k][1], win_y[k][0]), 1'b1));
          pass_fill[k] = srtp_pkg::FILL_EMPTY;
        end else begin
          pass_fill[k] = srtp_pkg::FILL_FULL;
        end
      end
      default: begin
        win_x[k][0] = win_x[k][1];
        win_y[k][0] = win_y[k][1];
        win_x[k][1] = win_x[k][2];
        win_y[k][1] = win_y[k][2];
        win_x[k][2] = s.x;
        win_y[k][2] = s.y;
        pass_out.push_back(make_pair(fix_mid(win_x[k][0], win_x[k][1], win_x[k][2]),
                                     fix_mid(win_y[k][0], win_y[k][1], win_y[k][2]), 1'b0));
        if (s.fin) begin
          pass_out.push_back(make_pair(fix_end(win_x[k][2], win_x[k][1], win_x[k][0]),
                                       fix_end(win_y[k][2], win_y[k][1], win_y[k][0]), 1'b1));
          pass_fill[k] = srtp_pkg::FILL_EMPTY;
        end
      end
    endcase
  endfunction

  // Run one accepted word through every pass and queue the cleaned words
  function automatic void predict_cleaned(srtp_pkg::in_word_t w);
    srtp_pkg::pair_t     stage [$];
    srtp_pkg::out_word_t ow;
    stage = {};
    stage.push_back(make_pair(w.shift_x, w.shift_y, w.is_final));
    for (int k = 0; k < PASSES; k++) begin
      pass_out.delete();
      foreach (stage[i]) pass_step(k, stage[i]);
      stage = pass_out;
    end
    foreach (stage[i]) begin
      ow.clean_x = stage[i].x;
      ow.clean_y = stage[i].y;
      ow.run_end = stage[i].fin;
      clean_words_due.push_back(ow);
    end
  endfunction

  // Driver: launch pending words, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) predict_cleaned(in_word);
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap = tx_gap - 1;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        in_word  <= pending_words.pop_front();
        tx_gap = $urandom_range(0, tx_max_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each cleaned word with the oldest one due
  always @(posedge clk) begin
    srtp_pkg::out_word_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (clean_words_due.size() == 0) begin
          $error("unexpected word: clean_x %0d clean_y %0d run_end %0d",
                 out_word.clean_x, out_word.clean_y, out_word.run_end);
          fail_count++;
        end else begin
          due = clean_words_due.pop_front();
          if (out_word.clean_x !== due.clean_x) begin
            $error("clean_x: expected %0d, got %0d", due.clean_x, out_word.clean_x);
            fail_count++;
          end
          if (out_word.clean_y !== due.clean_y) begin
            $error("clean_y: expected %0d, got %0d", due.clean_y, out_word.clean_y);
            fail_count++;
          end
          if (out_word.run_end !== due.run_end) begin
            $error("run_end: expected %0d, got %0d", due.run_end, out_word.run_end);
            fail_count++;
          end
        end
        rx_wait = $urandom_range(0, rx_max_gap);
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait = rx_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void queue_item(int x, int y, logic fin);
    srtp_pkg::in_word_t w;
    w.shift_x  = x[srtp_pkg::SAMPLE_W-1:0];
    w.shift_y  = y[srtp_pkg::SAMPLE_W-1:0];
    w.is_final = fin;
    pending_words.push_back(w);
  endfunction

  // Smooth walk with occasional spikes and full-range noise
  function automatic int draw_sample(int ch);
    logic [srtp_pkg::SAMPLE_W-1:0] raw;
    logic [31:0] raw_full;
    longint v;
    longint span;
    int pick;
    pick     = $urandom_range(0, 19);
    raw_full = $urandom;
    raw      = raw_full[srtp_pkg::SAMPLE_W-1:0];
    span = interior_tol + edge_tol;
    if (span < 200) span = 200;
    if (span > 40000) span = 40000;
    if (pick == 0) walk[ch] = longint'($signed(raw));
    else walk[ch] = sat_sample(walk[ch] + longint'($urandom_range(0, 64)) - 32);
    v = walk[ch];
    if (pick == 16) begin
      v = longint'($signed(raw));
    end else if (pick >= 17) begin
      if ($urandom_range(0, 1)) v = v + span / 2 + longint'($urandom_range(0, 32'(span)));
      else v = v - span / 2 - longint'($urandom_range(0, 32'(span)));
    end
    return int'(sat_sample(v));
  endfunction

  // Whole sequences only, so every phase ends with the windows flushed
  task automatic queue_random_runs(int n_items);
    int left;
    int len;
    int r;
    left = n_items;
    while (left > 0) begin
      r = $urandom_range(0, 9);
      if (r < 2) len = $urandom_range(1, 3);
      else if (r == 9) len = $urandom_range(17, 32);
      else len = $urandom_range(4, 16);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) queue_item(draw_sample(0), draw_sample(1), i == len - 1);
      left -= len;
    end
  endtask

  // Hold the sender until every due word has arrived, then let the block settle
  task automatic drain;
    while (pending_words.size() != 0 || in_valid || clean_words_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tol(logic [srtp_pkg::CFG_IDX_W-1:0] idx,
                           logic [srtp_pkg::TOL_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == srtp_pkg::REG_INTERIOR_TOL) interior_tol = longint'(val);
    else edge_tol = longint'(val);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset tolerances: short runs, interior and end spikes, saturation, rounding
    queue_item(32767, -32768, 1'b1);
    queue_item(-32768, 32767, 1'b0);
    queue_item(100, -100, 1'b1);
    queue_item(0, 0, 1'b0);
    queue_item(1000, -1000, 1'b0);
    queue_item(0, 0, 1'b1);
    queue_item(5000, -5000, 1'b0);
    queue_item(0, 0, 1'b0);
    queue_item(16, 16, 1'b0);
    queue_item(32, 32, 1'b0);
    queue_item(-3000, 3000, 1'b1);
    queue_item(-32768, 32767, 1'b0);
    queue_item(32000, -32000, 1'b0);
    queue_item(-32000, 32000, 1'b0);
    queue_item(-31000, 31000, 1'b1);
    queue_item(-3, 5, 1'b0);
    queue_item(1000, -1000, 1'b0);
    queue_item(-4, 8, 1'b1);
    drain();

    queue_random_runs(30);
    drain();
    queue_random_runs(30);
    drain();

    // Zero tolerance, no idling on either side
    write_tol(srtp_pkg::REG_INTERIOR_TOL, '0);
    write_tol(srtp_pkg::REG_EDGE_TOL, '0);
    tx_max_gap = 0;
    rx_max_gap = 0;
    queue_item(5, 5, 1'b0);
    queue_item(5, 5, 1'b0);
    queue_item(5, 5, 1'b1);
    queue_item(0, 0, 1'b0);
    queue_item(1, -1, 1'b0);
    queue_item(2, -2, 1'b0);
    queue_item(3, -3, 1'b1);
    queue_random_runs(40);
    drain();

    // Largest tolerances: only jumps of at least 32767 get replaced
    write_tol(srtp_pkg::REG_INTERIOR_TOL, '1);
    write_tol(srtp_pkg::REG_EDGE_TOL, '1);
    tx_max_gap = 7;
    rx_max_gap = 0;
    queue_random_runs(40);
    drain();

    write_tol(srtp_pkg::REG_INTERIOR_TOL, (srtp_pkg::TOL_W)'($urandom_range(0, 400)));
    write_tol(srtp_pkg::REG_EDGE_TOL, (srtp_pkg::TOL_W)'($urandom_range(0, 600)));
    tx_max_gap = 0;
    rx_max_gap = 7;
    queue_random_runs(50);
    drain();

    write_tol(srtp_pkg::REG_INTERIOR_TOL, '0);
    write_tol(srtp_pkg::REG_EDGE_TOL, '1);
    tx_max_gap = 7;
    rx_max_gap = 7;
    queue_random_runs(40);
    drain();

    write_tol(srtp_pkg::REG_INTERIOR_TOL, srtp_pkg::INTERIOR_TOL_RESET);
    write_tol(srtp_pkg::REG_EDGE_TOL, srtp_pkg::EDGE_TOL_RESET);
    queue_random_runs(70);
    drain();

    if (fail_count == 0 && clean_words_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
